/* src/u16u8_pkg.sv */
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

    // Width of a Unicode code point held between the front and the back.
    localparam int CP_W = 21;

    // Default depth of the code point queue between the two halves.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Upper six bits of a UTF-16 code unit that mark a surrogate half.
    localparam logic [5:0] SURR_HIGH_TAG = 6'h36;
    localparam logic [5:0] SURR_LOW_TAG  = 6'h37;

    // Offset added to a combined surrogate pair.
    localparam logic [CP_W-1:0] SUPP_PLANE_BASE = 21'h10000;

    // Status of the code point queue as seen by its neighbours.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

/* src/utf16_to_utf8_transcoder_unit.sv */
// Top level of the UTF-16 to UTF-8 transcoder.
// A code unit that completes a code point goes into the queue, then into the output
// register; surrogate highs give none. Throughput: one code unit per cycle while neither
// side stalls, set by the single-entry-per-cycle queue and output register; the queue
// lets either side stall without blocking the other at once.
// Reset (synchronous, active low) clears the pending surrogate, the queue and output valid.
module utf16_to_utf8_transcoder_unit #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_code_unit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_byte_count,
    output logic [7:0]  o_utf8_byte0,
    output logic [7:0]  o_utf8_byte1,
    output logic [7:0]  o_utf8_byte2,
    output logic [7:0]  o_utf8_byte3
);

    logic                          push;
    logic [u16u8_pkg::CP_W-1:0]    push_cp;
    logic                          pop;
    logic [u16u8_pkg::CP_W-1:0]    head_cp;
    u16u8_pkg::t_queue_status      q_status;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_code_unit (i_code_unit),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_cp   (push_cp)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_cp (push_cp),
        .i_pop     (pop),
        .o_head_cp (head_cp),
        .o_status  (q_status)
    );

    u16u8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_cp    (head_cp),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_byte_count (o_byte_count),
        .o_utf8_byte0 (o_utf8_byte0),
        .o_utf8_byte1 (o_utf8_byte1),
        .o_utf8_byte2 (o_utf8_byte2),
        .o_utf8_byte3 (o_utf8_byte3)
    );

endmodule

/* src/u16u8_front.sv */
// Front end: accepts code units, pairs surrogates and pushes code points.
module u16u8_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [15:0]                   i_code_unit,
    input  u16u8_pkg::t_queue_status      i_q_status,
    output logic                          o_push,
    output logic [u16u8_pkg::CP_W-1:0]    o_push_cp
);

    logic       r_pend_valid;
    logic       n_pend_valid;
    logic [9:0] r_pend_high;
    logic [9:0] n_pend_high;
    logic       accept;
    logic       is_high;
    logic       is_low;

    // Input transfers wait only while the queue is full.
    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;

    // Classify the unit by its upper six bits.
    assign is_high = (i_code_unit[15:10] == u16u8_pkg::SURR_HIGH_TAG);
    assign is_low  = (i_code_unit[15:10] == u16u8_pkg::SURR_LOW_TAG);

    // A code point leaves for every unit except a high half or an unpaired low half.
    assign o_push = accept && !is_high && !(is_low && !r_pend_valid);

    // Build the code point: a paired surrogate or the unit itself.
    always_comb begin
        if (is_low) begin
            o_push_cp = u16u8_pkg::SUPP_PLANE_BASE + {1'b0, r_pend_high, i_code_unit[9:0]};
        end else begin
            o_push_cp = {5'd0, i_code_unit};
        end
    end

    // Next value of the pending high surrogate.
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_high  = r_pend_high;
        if (accept) begin
            priority if (is_high) begin
                n_pend_valid = 1'b1;
                n_pend_high  = i_code_unit[9:0];
            end else if (is_low && !r_pend_valid) begin
                n_pend_valid = r_pend_valid;
                n_pend_high  = r_pend_high;
            end else begin
                n_pend_valid = 1'b0;
                n_pend_high  = 10'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_high  <= 10'd0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_pend_high  <= n_pend_high;
        end
    end

    // An accepted high half is always pending on the next cycle.
    a_high_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_high |=> r_pend_valid)
        else $error("high surrogate not held as pending");

    // A high half never produces a code point.
    a_high_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_high |-> !o_push)
        else $error("code point pushed for a high surrogate");

endmodule

/* src/u16u8_queue.sv */
// Short code point queue that decouples the front end from the encoder.
module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [u16u8_pkg::CP_W-1:0]    i_push_cp,
    input  logic                          i_pop,
    output logic [u16u8_pkg::CP_W-1:0]    o_head_cp,
    output u16u8_pkg::t_queue_status      o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [u16u8_pkg::CP_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]           r_wr_ptr;
    logic [PTR_W-1:0]           n_wr_ptr;
    logic [PTR_W-1:0]           r_rd_ptr;
    logic [PTR_W-1:0]           n_rd_ptr;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head_cp      = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset; entries are only read after being written.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cp;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("pop from an empty queue");

endmodule

/* src/u16u8_back.sv */
// Back end: encodes queued code points into UTF-8 and holds the result.
module u16u8_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [u16u8_pkg::CP_W-1:0]    i_head_cp,
    input  u16u8_pkg::t_queue_status      i_q_status,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_byte_count,
    output logic [7:0]                    o_utf8_byte0,
    output logic [7:0]                    o_utf8_byte1,
    output logic [7:0]                    o_utf8_byte2,
    output logic [7:0]                    o_utf8_byte3
);

    logic       r_valid;
    logic       n_valid;
    logic [2:0] r_count;
    logic [7:0] r_b0;
    logic [7:0] r_b1;
    logic [7:0] r_b2;
    logic [7:0] r_b3;
    logic [2:0] enc_count;
    logic [7:0] enc_b0;
    logic [7:0] enc_b1;
    logic [7:0] enc_b2;
    logic [7:0] enc_b3;
    logic       out_free;

    // The output register takes a new result when empty or being drained.
    assign out_free = !r_valid || !i_out_stall;
    assign o_pop    = out_free && !i_q_status.empty;

    // Standard UTF-8 encoding by code point range.
    always_comb begin
        enc_b1 = 8'd0;
        enc_b2 = 8'd0;
        enc_b3 = 8'd0;
        priority if (i_head_cp < 21'h80) begin
            enc_count = 3'd1;
            enc_b0    = {1'b0, i_head_cp[6:0]};
        end else if (i_head_cp < 21'h800) begin
            enc_count = 3'd2;
            enc_b0    = {3'b110, i_head_cp[10:6]};
            enc_b1    = {2'b10, i_head_cp[5:0]};
        end else if (i_head_cp < 21'h10000) begin
            enc_count = 3'd3;
            enc_b0    = {4'b1110, i_head_cp[15:12]};
            enc_b1    = {2'b10, i_head_cp[11:6]};
            enc_b2    = {2'b10, i_head_cp[5:0]};
        end else begin
            enc_count = 3'd4;
            enc_b0    = {5'b11110, i_head_cp[20:18]};
            enc_b1    = {2'b10, i_head_cp[17:12]};
            enc_b2    = {2'b10, i_head_cp[11:6]};
            enc_b3    = {2'b10, i_head_cp[5:0]};
        end
    end

    // Output valid follows pops and completed transfers.
    always_comb begin
        n_valid = r_valid;
        if (out_free) begin
            n_valid = o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Result payload loads on each pop.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_count <= enc_count;
            r_b0    <= enc_b0;
            r_b1    <= enc_b1;
            r_b2    <= enc_b2;
            r_b3    <= enc_b3;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_byte_count = r_count;
    assign o_utf8_byte0 = r_b0;
    assign o_utf8_byte1 = r_b1;
    assign o_utf8_byte2 = r_b2;
    assign o_utf8_byte3 = r_b3;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_count == 3'd1 || r_count == 3'd2 || r_count == 3'd3
                     || r_count == 3'd4))
        else $error("byte count out of range");

    a_single_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_count == 3'd1 |-> r_b1 == 8'd0 && r_b0[7] == 1'b0)
        else $error("single byte result malformed");

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the UTF-16 to UTF-8 transcoder top level.
`timescale 1ns / 100ps

module tb_top;

    // One UTF-8 result as it leaves the block.
    typedef struct packed {
        logic [2:0] count;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } t_utf8_result;

    // How a stimulus row is checked.
    typedef enum logic [1:0] {
        ROW_CHECKED,
        ROW_NO_RESULT,
        ROW_TYPED
    } t_row_kind;

    // What a code unit does to the transcoder.
    typedef enum logic [1:0] {
        UNIT_HELD,
        UNIT_DROPPED,
        UNIT_ENCODED
    } t_unit_effect;

    typedef struct packed {
        logic [15:0]  unit;
        t_row_kind    kind;
        t_utf8_result want;
    } t_dir_row;

    typedef struct packed {
        logic [15:0]  unit;
        t_row_kind    kind;
        t_utf8_result want;
        logic [1:0]   phase;
    } t_stim_item;

    localparam int DIR_ROWS      = 26;
    localparam int RAND_UNITS    = 1874;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int REPORT_CAP    = 40;

    // Idle and stall odds per phase: none, sender, receiver, both.
    localparam int SEND_IDLE_PCT [4] = '{0, 84, 0, 33};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 84, 33};

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [15:0] i_code_unit  = 16'h0000;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_byte_count;
    logic [7:0]  o_utf8_byte0;
    logic [7:0]  o_utf8_byte1;
    logic [7:0]  o_utf8_byte2;
    logic [7:0]  o_utf8_byte3;

    utf16_to_utf8_transcoder_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_code_unit  (i_code_unit),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_byte_count (o_byte_count),
        .o_utf8_byte0 (o_utf8_byte0),
        .o_utf8_byte1 (o_utf8_byte1),
        .o_utf8_byte2 (o_utf8_byte2),
        .o_utf8_byte3 (o_utf8_byte3)
    );

    // Shadow of the pending high surrogate.
    logic         pend_valid = 1'b0;
    logic [9:0]   pend_bits  = 10'd0;

    t_stim_item   stim_q[$];
    t_utf8_result utf8_expected_q[$];
    t_stim_item   cur_item;
    t_unit_effect cur_effect;
    t_utf8_result cur_result;
    int           next_idx       = 0;
    int           transfers_in   = 0;
    int           results_seen   = 0;
    int           fault_count    = 0;
    int           idle_cycles    = 0;
    int           cur_phase      = 0;
    int           len_hist[1:4]  = '{0, 0, 0, 0};

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Prints one line per fault, up to a cap, and counts every one.
    task automatic report_fault(input string msg);
        if (fault_count < REPORT_CAP) begin
            $display("[%0t] FAULT: %s", $realtime, msg);
        end
        fault_count++;
    endtask

    // Works out the UTF-8 bytes caused by one code unit and updates the shadow state.
    task automatic transcode_unit(input logic [15:0] unit, output t_unit_effect effect,
                                  output t_utf8_result res);
        logic [20:0] cp;
        res = '0;
        cp  = '0;
        if (unit[15:10] == u16u8_pkg::SURR_HIGH_TAG) begin
            // A new high always replaces any pending one.
            pend_valid = 1'b1;
            pend_bits  = unit[9:0];
            effect     = UNIT_HELD;
        end else if (unit[15:10] == u16u8_pkg::SURR_LOW_TAG && !pend_valid) begin
            effect = UNIT_DROPPED;
        end else begin
            if (unit[15:10] == u16u8_pkg::SURR_LOW_TAG) begin
                cp = u16u8_pkg::SUPP_PLANE_BASE + {1'b0, pend_bits, unit[9:0]};
            end else begin
                cp = {5'd0, unit};
            end
            pend_valid = 1'b0;
            pend_bits  = 10'd0;
            effect     = UNIT_ENCODED;
            if (cp < 21'h80) begin
                res.count = 3'd1;
                res.b0    = cp[7:0];
            end else if (cp < 21'h800) begin
                res.count = 3'd2;
                res.b0    = {3'b110, cp[10:6]};
                res.b1    = {2'b10, cp[5:0]};
            end else if (cp < 21'h10000) begin
                res.count = 3'd3;
                res.b0    = {4'b1110, cp[15:12]};
                res.b1    = {2'b10, cp[11:6]};
                res.b2    = {2'b10, cp[5:0]};
            end else begin
                res.count = 3'd4;
                res.b0    = {5'b11110, cp[20:18]};
                res.b1    = {2'b10, cp[17:12]};
                res.b2    = {2'b10, cp[11:6]};
                res.b3    = {2'b10, cp[5:0]};
            end
        end
    endtask

    // Compares one result transfer with the oldest expectation.
    task automatic check_result();
        t_utf8_result want;
        t_utf8_result got;
        got = '{o_byte_count, o_utf8_byte0, o_utf8_byte1, o_utf8_byte2, o_utf8_byte3};
        if (utf8_expected_q.size() == 0) begin
            report_fault($sformatf("result %h with nothing expected", got));
        end else begin
            want = utf8_expected_q.pop_front();
            if (got.count != want.count)
                report_fault($sformatf("byte_count %0d, expected %0d", got.count, want.count));
            if (got.b0 != want.b0)
                report_fault($sformatf("utf8_byte0 %h, expected %h", got.b0, want.b0));
            if (got.b1 != want.b1)
                report_fault($sformatf("utf8_byte1 %h, expected %h", got.b1, want.b1));
            if (got.b2 != want.b2)
                report_fault($sformatf("utf8_byte2 %h, expected %h", got.b2, want.b2));
            if (got.b3 != want.b3)
                report_fault($sformatf("utf8_byte3 %h, expected %h", got.b3, want.b3));
            if (want.count >= 3'd1 && want.count <= 3'd4) begin
                len_hist[want.count]++;
            end
        end
        results_seen++;
    endtask

    // Drives both channels and checks results, all sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_result();
            end
            i_out_stall <= ($urandom_range(0, 99) < RECV_STALL_PCT[cur_phase]);

            // An accepted code unit updates the shadow and files its expectation.
            if (i_in_valid && !o_in_stall) begin
                transcode_unit(cur_item.unit, cur_effect, cur_result);
                if (cur_item.kind == ROW_TYPED) begin
                    utf8_expected_q.push_back(cur_item.want);
                end else if (cur_item.kind == ROW_CHECKED && cur_effect == UNIT_ENCODED) begin
                    utf8_expected_q.push_back(cur_result);
                end
                transfers_in++;
            end

            // A new unit is offered only once the previous one has gone.
            if (!i_in_valid || !o_in_stall) begin
                if (next_idx < stim_q.size() &&
                    $urandom_range(0, 99) >= SEND_IDLE_PCT[stim_q[next_idx].phase]) begin
                    cur_item = stim_q[next_idx];
                    cur_phase = cur_item.phase;
                    next_idx++;
                    i_in_valid  <= 1'b1;
                    i_code_unit <= cur_item.unit;
                end else begin
                    i_in_valid  <= 1'b0;
                    i_code_unit <= 16'($urandom());
                end
            end
        end
    end

    // Ends the run if no transfer happens on either channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, STALL_LIMIT);
                $display("utf16_to_utf8_transcoder_unit verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Builds the stimulus, releases reset and waits for the block to drain.
    initial begin
        t_dir_row    dir_rows [DIR_ROWS];
        logic [15:0] unit;
        logic        carry_low;
        int          counted;
        int          roll;

        // Directed rows: extremes of each length, surrogate corner cases.
        dir_rows = '{
            '{16'h0000, ROW_TYPED,     {3'd1, 32'h00_00_00_00}},
            '{16'h007F, ROW_TYPED,     {3'd1, 32'h7F_00_00_00}},
            '{16'h0080, ROW_TYPED,     {3'd2, 32'hC2_80_00_00}},
            '{16'h07FF, ROW_TYPED,     {3'd2, 32'hDF_BF_00_00}},
            '{16'h0800, ROW_TYPED,     {3'd3, 32'hE0_A0_80_00}},
            '{16'hFFFF, ROW_TYPED,     {3'd3, 32'hEF_BF_BF_00}},
            '{16'hDC00, ROW_NO_RESULT, '0},
            '{16'hDFFF, ROW_NO_RESULT, '0},
            '{16'hD800, ROW_NO_RESULT, '0},
            '{16'hDC00, ROW_TYPED,     {3'd4, 32'hF0_90_80_80}},
            '{16'hDBFF, ROW_NO_RESULT, '0},
            '{16'hDFFF, ROW_TYPED,     {3'd4, 32'hF4_8F_BF_BF}},
            '{16'hD800, ROW_NO_RESULT, '0},
            '{16'hDBFF, ROW_NO_RESULT, '0},
            '{16'hDC00, ROW_CHECKED,   '0},
            '{16'hD834, ROW_NO_RESULT, '0},
            '{16'h0041, ROW_TYPED,     {3'd1, 32'h41_00_00_00}},
            '{16'hDD1E, ROW_NO_RESULT, '0},
            '{16'hD834, ROW_NO_RESULT, '0},
            '{16'hDD1E, ROW_CHECKED,   '0},
            '{16'h00E9, ROW_CHECKED,   '0},
            '{16'h20AC, ROW_CHECKED,   '0},
            '{16'hE000, ROW_CHECKED,   '0},
            '{16'hD7FF, ROW_CHECKED,   '0},
            '{16'hD800, ROW_NO_RESULT, '0},
            '{16'h0000, ROW_TYPED,     {3'd1, 32'h00_00_00_00}}
        };
        for (int i = 0; i < DIR_ROWS; i++) begin
            stim_q.push_back('{dir_rows[i].unit, dir_rows[i].kind, dir_rows[i].want, 2'd0});
        end

        // Random units: mostly well-formed text with surrogate pairs, some noise.
        carry_low   = 1'b0;
        counted     = 0;
        while (counted < RAND_UNITS) begin
            if (carry_low) begin
                unit      = {u16u8_pkg::SURR_LOW_TAG, 10'($urandom())};
                carry_low = 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 15) begin
                    unit = 16'($urandom_range(16'h0000, 16'h007F));
                end else if (roll < 30) begin
                    unit = 16'($urandom_range(16'h0080, 16'h07FF));
                end else if (roll < 45) begin
                    unit = 16'($urandom_range(16'h0800, 16'hFFFF));
                    while (unit[15:11] == 5'b11011) begin
                        unit = 16'($urandom_range(16'h0800, 16'hFFFF));
                    end
                end else if (roll < 75) begin
                    unit      = {u16u8_pkg::SURR_HIGH_TAG, 10'($urandom())};
                    carry_low = 1'b1;
                end else if (roll < 83) begin
                    unit = {u16u8_pkg::SURR_LOW_TAG, 10'($urandom())};
                end else if (roll < 91) begin
                    unit = {u16u8_pkg::SURR_HIGH_TAG, 10'($urandom())};
                end else begin
                    unit = 16'($urandom());
                end
            end
            stim_q.push_back('{unit, ROW_CHECKED, '0, 2'((counted * 4) / RAND_UNITS)});
            counted++;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every unit has gone in and every result has come out.
        while (transfers_in < stim_q.size() || utf8_expected_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (utf8_expected_q.size() != 0) begin
            report_fault($sformatf("%0d results never arrived", utf8_expected_q.size()));
        end

        $display("Summary: %0d code units transferred (%0d directed), %0d results checked",
                 transfers_in, DIR_ROWS, results_seen);
        $display("Result lengths 1/2/3/4 bytes: %0d/%0d/%0d/%0d over four idle/stall phases",
                 len_hist[1], len_hist[2], len_hist[3], len_hist[4]);
        if (fault_count == 0) begin
            $display("utf16_to_utf8_transcoder_unit verification clean");
        end else begin
            $display("utf16_to_utf8_transcoder_unit verification failed");
        end
        $finish;
    end

endmodule
